// ----- design/rmth_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared types and sizes for the two-heap running median block.
// ----------------------------------------------------------------------------
package rmth_pkg;

    // Store capacity and the derived heap geometry.
    localparam int CAPACITY    = 1024;
    localparam int HEAP_DEPTH  = CAPACITY / 2;
    localparam int ADDR_W      = $clog2(HEAP_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int COUNT_W     = 11;

    // Heap selectors.
    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               restart;
    } t_in;

    typedef struct packed {
        logic signed [32:0]   median_times_two;
        logic [COUNT_W-1:0]   held_count;
        logic                 rejected;
    } t_out;

endpackage
`default_nettype wire

// ----- design/running_median_two_heaps.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An input is either rejected, or runs as one push that sifts up, or as a pop that sifts down
// and then two pushes that sift up; each level sifted is one memory read and one write-back.
// The result is offered once the last push ends.
// One item at a time: a new input is taken only in idle, after the last result has transferred.
// Reset: synchronous, active low; both heap sizes clear, heap RAM is not cleared.
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median over a signed stream, kept in a max-heap and a min-heap in RAM.
// ----------------------------------------------------------------------------
module running_median_two_heaps (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire rmth_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output rmth_pkg::t_out    o_out_data
);
    import rmth_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_POP_LAST, S_POP_CMP, S_POP_WR, S_POP_END,
        S_PUSH_CMP, S_PUSH_WR, S_OUT
    } t_state;

    // A ranks above b: greater for the max-heap, smaller for the min-heap.
    function automatic logic ranks_above(input logic signed [31:0] a,
                                         input logic signed [31:0] b,
                                         input logic sel);
        return sel ? (a < b) : (a > b);
    endfunction

    t_state                  r_state, n_state;
    logic                    r_sel, n_sel;
    logic [ADDR_W-1:0]       r_idx, n_idx;
    logic signed [31:0]      r_val, n_val;
    logic signed [31:0]      r_x, n_x;
    logic signed [31:0]      r_t, n_t;
    logic                    r_more, n_more;
    logic                    r_rej, n_rej;
    logic [SIZE_W-1:0]       r_size [2];
    logic [SIZE_W-1:0]       n_size [2];
    logic signed [31:0]      r_top [2];
    logic signed [31:0]      n_top [2];

    // Memory ports, one set per heap.
    logic                    w_we  [2];
    logic [ADDR_W-1:0]       w_wa  [2];
    logic signed [31:0]      w_wd  [2];
    logic [ADDR_W-1:0]       w_ra0 [2];
    logic [ADDR_W-1:0]       w_ra1 [2];
    logic signed [31:0]      mem_lo [HEAP_DEPTH];
    logic signed [31:0]      mem_up [HEAP_DEPTH];
    logic signed [31:0]      r_lo_rd0, r_lo_rd1, r_up_rd0, r_up_rd1;

    // Sequencing helpers.
    logic                    pop_go, pop_done, push_go, push_done;
    logic                    pop_sel, push_sel;
    logic signed [31:0]      push_val;
    logic signed [31:0]      rd0, rd1, child;
    logic [SIZE_W-1:0]       lchild, rchild, nlchild, cnt_sz, nsz;
    logic [ADDR_W-1:0]       best, parent;
    logic [COUNT_W-1:0]      total;
    logic                    odd;
    logic signed [32:0]      lo_v, hi_v;

    assign rd0 = r_sel ? r_up_rd0 : r_lo_rd0;
    assign rd1 = r_sel ? r_up_rd1 : r_lo_rd1;

    // Next-state, memory access and heap sequencing.
    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        n_idx    = r_idx;
        n_val    = r_val;
        n_x      = r_x;
        n_t      = r_t;
        n_more   = r_more;
        n_rej    = r_rej;
        n_size   = r_size;
        n_top    = r_top;
        for (int h = 0; h < 2; h++) begin
            w_we[h]  = 1'b0;
            w_wa[h]  = '0;
            w_wd[h]  = '0;
            w_ra0[h] = '0;
            w_ra1[h] = '0;
        end
        pop_go    = 1'b0;
        pop_done  = 1'b0;
        push_go   = 1'b0;
        push_done = 1'b0;
        pop_sel   = 1'b0;
        push_sel  = 1'b0;
        push_val  = '0;
        cnt_sz    = r_size[r_sel];
        lchild    = {r_idx, 1'b1};
        rchild    = lchild + SIZE_W'(1);
        child     = rd0;
        best      = lchild[ADDR_W-1:0];
        nlchild   = '0;
        parent    = '0;
        nsz       = '0;
        total     = '0;
        odd       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x   = i_in_data.sample;
                    n_rej = 1'b0;
                    if (i_in_data.restart) begin
                        n_size[0] = '0;
                        n_size[1] = '0;
                    end
                    total = COUNT_W'(n_size[0]) + COUNT_W'(n_size[1]);
                    odd   = n_size[0] > n_size[1];
                    if (total >= COUNT_W'(CAPACITY)) begin
                        n_rej   = 1'b1;
                        n_state = S_OUT;
                    end else if (odd) begin
                        if (i_in_data.sample < r_top[0]) begin
                            pop_go  = 1'b1;
                            pop_sel = HEAP_LOWER;
                            n_t     = r_top[0];
                            n_more  = 1'b1;
                        end else begin
                            push_go  = 1'b1;
                            push_sel = HEAP_UPPER;
                            push_val = i_in_data.sample;
                            n_more   = 1'b0;
                        end
                    end else begin
                        if (n_size[1] != '0 && i_in_data.sample > r_top[1]) begin
                            pop_go  = 1'b1;
                            pop_sel = HEAP_UPPER;
                            n_t     = r_top[1];
                            n_more  = 1'b1;
                        end else begin
                            push_go  = 1'b1;
                            push_sel = HEAP_LOWER;
                            push_val = i_in_data.sample;
                            n_more   = 1'b0;
                        end
                    end
                end
            end
            S_POP_LAST: begin
                // The last entry fills the hole at the root and sifts down.
                n_val = rd0;
                n_idx = '0;
                if (SIZE_W'(1) >= cnt_sz) begin
                    w_we[r_sel] = 1'b1;
                    w_wa[r_sel] = '0;
                    w_wd[r_sel] = rd0;
                    pop_done    = 1'b1;
                end else begin
                    w_ra0[r_sel] = ADDR_W'(1);
                    w_ra1[r_sel] = ADDR_W'(2);
                    n_state      = S_POP_CMP;
                end
            end
            S_POP_CMP: begin
                if (rchild < cnt_sz && ranks_above(rd1, rd0, r_sel)) begin
                    child = rd1;
                    best  = rchild[ADDR_W-1:0];
                end
                w_we[r_sel] = 1'b1;
                w_wa[r_sel] = r_idx;
                if (ranks_above(child, r_val, r_sel)) begin
                    w_wd[r_sel] = child;
                    n_idx       = best;
                    nlchild     = {best, 1'b1};
                    if (nlchild >= cnt_sz) begin
                        n_state = S_POP_WR;
                    end else begin
                        w_ra0[r_sel] = nlchild[ADDR_W-1:0];
                        w_ra1[r_sel] = ADDR_W'(nlchild + SIZE_W'(1));
                    end
                end else begin
                    w_wd[r_sel] = r_val;
                    pop_done    = 1'b1;
                end
            end
            S_POP_WR: begin
                w_we[r_sel] = 1'b1;
                w_wa[r_sel] = r_idx;
                w_wd[r_sel] = r_val;
                pop_done    = 1'b1;
            end
            S_POP_END: begin
                pop_done = 1'b1;
            end
            S_PUSH_CMP: begin
                // rd0 holds the parent of the hole.
                parent      = (r_idx - ADDR_W'(1)) >> 1;
                w_we[r_sel] = 1'b1;
                w_wa[r_sel] = r_idx;
                if (ranks_above(r_val, rd0, r_sel)) begin
                    w_wd[r_sel] = rd0;
                    n_idx       = parent;
                    if (parent == '0) begin
                        n_state = S_PUSH_WR;
                    end else begin
                        w_ra0[r_sel] = (parent - ADDR_W'(1)) >> 1;
                    end
                end else begin
                    w_wd[r_sel] = r_val;
                    push_done   = 1'b1;
                end
            end
            S_PUSH_WR: begin
                w_we[r_sel] = 1'b1;
                w_wa[r_sel] = r_idx;
                w_wd[r_sel] = r_val;
                push_done   = 1'b1;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Start a pop: shrink the heap and fetch its last entry.
        if (pop_go) begin
            nsz             = n_size[pop_sel] - SIZE_W'(1);
            n_size[pop_sel] = nsz;
            n_sel           = pop_sel;
            if (nsz == '0) begin
                n_state = S_POP_END;
            end else begin
                w_ra0[pop_sel] = nsz[ADDR_W-1:0];
                n_state        = S_POP_LAST;
            end
        end

        // The popped top moves to the other heap; then the sample follows.
        if (pop_done) begin
            push_go  = 1'b1;
            push_sel = ~r_sel;
            push_val = r_t;
        end
        if (push_done) begin
            if (r_more) begin
                n_more   = 1'b0;
                push_go  = 1'b1;
                push_sel = ~r_sel;
                push_val = r_x;
            end else begin
                n_state = S_OUT;
            end
        end

        // Start a push: open a hole at the end and sift it up.
        if (push_go) begin
            n_idx            = n_size[push_sel][ADDR_W-1:0];
            n_size[push_sel] = n_size[push_sel] + SIZE_W'(1);
            n_sel            = push_sel;
            n_val            = push_val;
            if (n_idx == '0) begin
                n_state = S_PUSH_WR;
            end else begin
                w_ra0[push_sel] = (n_idx - ADDR_W'(1)) >> 1;
                n_state         = S_PUSH_CMP;
            end
        end

        // Mirror each heap's root in a register.
        for (int h = 0; h < 2; h++) begin
            if (w_we[h] && w_wa[h] == '0) begin
                n_top[h] = w_wd[h];
            end
        end
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_size[0] <= '0;
            r_size[1] <= '0;
            r_more    <= 1'b0;
            r_rej     <= 1'b0;
            r_sel     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_more  <= n_more;
            r_rej   <= n_rej;
            r_sel   <= n_sel;
        end
        r_idx <= n_idx;
        r_val <= n_val;
        r_x   <= n_x;
        r_t   <= n_t;
        r_top <= n_top;
    end

    // Lower-half max-heap storage.
    always_ff @(posedge i_clk) begin
        if (w_we[0]) begin
            mem_lo[w_wa[0]] <= w_wd[0];
        end
        r_lo_rd0 <= mem_lo[w_ra0[0]];
        r_lo_rd1 <= mem_lo[w_ra1[0]];
    end

    // Upper-half min-heap storage.
    always_ff @(posedge i_clk) begin
        if (w_we[1]) begin
            mem_up[w_wa[1]] <= w_wd[1];
        end
        r_up_rd0 <= mem_up[w_ra0[1]];
        r_up_rd1 <= mem_up[w_ra1[1]];
    end

    // Result: twice the median from the two roots.
    always_comb begin
        lo_v = (r_size[0] != '0) ? 33'(r_top[0]) : '0;
        hi_v = (r_size[1] != '0) ? 33'(r_top[1]) : '0;
        o_out_data.median_times_two = (r_size[0] > r_size[1]) ? (lo_v <<< 1)
                                                              : (lo_v + hi_v);
        o_out_data.held_count = COUNT_W'(r_size[0]) + COUNT_W'(r_size[1]);
        o_out_data.rejected   = r_rej;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule
`default_nettype wire

// ----- design/rmth_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_checker
// Port-level checks for the running median block.
// ----------------------------------------------------------------------------
module rmth_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              o_in_ready,
    input wire rmth_pkg::t_in  i_in_data,
    input wire              o_out_valid,
    input wire              i_out_ready,
    input wire rmth_pkg::t_out o_out_data
);
    import rmth_pkg::*;

    // A pending result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed before transfer");

    // One item at a time: an input transfer closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // A result always reports a nonempty store.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.held_count != '0)
        else $error("empty store reported");

    // A dropped sample means the store was full.
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rejected |->
            o_out_data.held_count == COUNT_W'(CAPACITY))
        else $error("sample dropped below capacity");

endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (.*);
`default_nettype wire
